[design/mbd_pkg.sv]
// Shared types and constants for the mip level 2x2 box downsampler.
// No dependencies; imported by every module of the block but mbd_ram.
package mbd_pkg;

  localparam int CFG_W             = 12;
  localparam int REG_INDEX_W       = 1;
  localparam int PIXEL_W           = 32;
  localparam int CH_SUM_W          = 9;
  localparam int SUM_W             = 4 * CH_SUM_W;
  localparam int ROW_W             = 11;
  localparam int MAX_HEIGHT        = 2048;
  localparam int MAX_WIDTH_DEFAULT = 2048;
  localparam int QUEUE_DEPTH       = 4;
  localparam int COUNT_W           = $clog2(QUEUE_DEPTH + 1);

  localparam logic [REG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 1'b0;
  localparam logic [REG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 1'b1;

  typedef enum logic {
    KIND_MEAN2,
    KIND_MEAN4
  } kind_t;

  // One pending result: line-store pair sums, current pair sums, and flags.
  typedef struct packed {
    kind_t             kind;
    logic              last;
    logic [SUM_W-1:0]  sum_a;
    logic [SUM_W-1:0]  sum_b;
  } entry_t;

endpackage

[design/mbd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mbd_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    write_enable,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] write_address,
  input  logic [WIDTH-1:0]                        write_data,
  input  logic                                    read_enable,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] read_address,
  output logic [WIDTH-1:0]                        read_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (write_enable) begin
      mem[write_address] <= write_data;
    end
    if (read_enable) begin
      read_data <= mem[read_address];
    end
  end

endmodule

[design/mbd_front.sv]
// Front end: configuration, position counters, item classification and the line store.
// Depends on mbd_pkg and mbd_ram.
module mbd_front #(
  parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            write_enable,
  input  logic [mbd_pkg::REG_INDEX_W-1:0] write_index,
  input  logic [mbd_pkg::CFG_W-1:0]       write_data,
  input  logic                            source_valid,
  output logic                            source_stall,
  input  logic [mbd_pkg::PIXEL_W-1:0]     source_pixel,
  input  logic [mbd_pkg::COUNT_W-1:0]     queue_count,
  output logic                            push,
  output mbd_pkg::entry_t                 push_entry
);
  import mbd_pkg::*;

  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam logic [13:0] MAX_W_L = 14'(MAX_WIDTH);

  logic [CFG_W-1:0]   source_width;
  logic [CFG_W-1:0]   source_height;
  logic [CFG_W-1:0]   column_index;
  logic [ROW_W-1:0]   row_index;
  logic [PIXEL_W-1:0] held_pixel;
  logic               stage_valid;
  kind_t              stage_kind;
  logic               stage_last;
  logic [SUM_W-1:0]   stage_sum;

  logic [CFG_W-1:0]   w_nz, h_nz, eff_w, eff_h, wend, hend, col_inc, row_inc;
  logic               w_one, h_one, x_last_pair, y_last_pair, col_wrap, row_wrap;
  logic               accept, hold_en, line_write, line_read, emit, emit_last;
  kind_t              emit_kind;
  logic [SUM_W-1:0]   cur_sum, line_data;
  logic [ADDR_W-1:0]  slot;

  function automatic logic [SUM_W-1:0] pair_sums(input logic [PIXEL_W-1:0] a,
                                                 input logic [PIXEL_W-1:0] b);
    logic [SUM_W-1:0] s;
    for (int c = 0; c < 4; c++) begin
      s[c*CH_SUM_W +: CH_SUM_W] = {1'b0, a[c*8 +: 8]} + {1'b0, b[c*8 +: 8]};
    end
    return s;
  endfunction

  assign accept = source_valid && !source_stall;

  // One slot is held back while an item sits in the line-read stage.
  assign source_stall = stage_valid ? (queue_count >= COUNT_W'(QUEUE_DEPTH - 1))
                                    : (queue_count >= COUNT_W'(QUEUE_DEPTH));

  // Zero acts as one; widths clamp to MAX_WIDTH and heights to MAX_HEIGHT.
  assign w_nz  = (source_width == '0) ? CFG_W'(1) : source_width;
  assign h_nz  = (source_height == '0) ? CFG_W'(1) : source_height;
  assign eff_w = (14'(w_nz) > MAX_W_L) ? CFG_W'(MAX_WIDTH) : w_nz;
  assign eff_h = (h_nz > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : h_nz;
  assign wend  = {eff_w[CFG_W-1:1], 1'b0};
  assign hend  = {eff_h[CFG_W-1:1], 1'b0};
  assign w_one = (eff_w == CFG_W'(1));
  assign h_one = (eff_h == CFG_W'(1));

  assign col_inc     = column_index + CFG_W'(1);
  assign row_inc     = {1'b0, row_index} + CFG_W'(1);
  assign x_last_pair = (col_inc == wend);
  assign y_last_pair = (row_inc == hend);
  assign col_wrap    = (col_inc >= eff_w);
  assign row_wrap    = (row_inc >= eff_h);

  assign cur_sum = pair_sums(held_pixel, source_pixel);
  assign slot    = ADDR_W'(column_index >> 1);

  always_comb begin
    hold_en    = 1'b0;
    line_write = 1'b0;
    line_read  = 1'b0;
    emit       = 1'b0;
    emit_kind  = KIND_MEAN2;
    emit_last  = 1'b0;
    if (w_one && h_one) begin
      // single pixel level: consumed, nothing out
    end else if (w_one) begin
      if (!row_index[0]) begin
        hold_en = 1'b1;
      end else begin
        emit      = 1'b1;
        emit_last = y_last_pair;
      end
    end else if (h_one) begin
      if (!column_index[0]) begin
        hold_en = 1'b1;
      end else begin
        emit      = 1'b1;
        emit_last = x_last_pair;
      end
    end else if (!column_index[0]) begin
      hold_en = 1'b1;
    end else if (!row_index[0]) begin
      line_write = 1'b1;
    end else begin
      line_read = 1'b1;
      emit      = 1'b1;
      emit_kind = KIND_MEAN4;
      emit_last = x_last_pair && y_last_pair;
    end
  end

  mbd_ram #(
    .WIDTH(SUM_W),
    .DEPTH(LINE_DEPTH)
  ) u_line (
    .clk          (clk),
    .write_enable (accept && line_write),
    .write_address(slot),
    .write_data   (cur_sum),
    .read_enable  (accept && line_read),
    .read_address (slot),
    .read_data    (line_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= CFG_W'(1);
      source_height <= CFG_W'(1);
      column_index  <= '0;
      row_index     <= '0;
      held_pixel    <= '0;
      stage_valid   <= 1'b0;
    end else begin
      if (write_enable) begin
        unique case (write_index)
          REG_SOURCE_WIDTH:  source_width  <= write_data;
          REG_SOURCE_HEIGHT: source_height <= write_data;
        endcase
        column_index <= '0;
        row_index    <= '0;
      end else if (accept) begin
        if (col_wrap) begin
          column_index <= '0;
          row_index    <= row_wrap ? '0 : ROW_W'(row_inc);
        end else begin
          column_index <= col_inc;
        end
      end
      if (accept && hold_en) begin
        held_pixel <= source_pixel;
      end
      stage_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_kind <= emit_kind;
      stage_last <= emit_last;
      stage_sum  <= cur_sum;
    end
  end

  // Line data lands in the same cycle as the stage register.
  assign push             = stage_valid;
  assign push_entry.kind  = stage_kind;
  assign push_entry.last  = stage_last;
  assign push_entry.sum_a = line_data;
  assign push_entry.sum_b = stage_sum;

endmodule

[design/mbd_queue.sv]
// Short queue of pending results between the front end and the averaging back end.
// Depends on mbd_pkg.
module mbd_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  mbd_pkg::entry_t             push_entry,
  input  logic                        pop,
  output logic                        head_valid,
  output mbd_pkg::entry_t             head_entry,
  output logic [mbd_pkg::COUNT_W-1:0] count
);
  import mbd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  entry_t           entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_pop;

  assign head_valid = (count != '0);
  assign head_entry = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + COUNT_W'(1);
      end else if (do_pop && !push) begin
        count <= count - COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

[design/mbd_back.sv]
// Back end: per-channel truncated mean of a queued item and the output register.
// Depends on mbd_pkg.
module mbd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  mbd_pkg::entry_t             head_entry,
  output logic                        pop,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [mbd_pkg::PIXEL_W-1:0] result_pixel,
  output logic                        last_of_level
);
  import mbd_pkg::*;

  logic [PIXEL_W-1:0] mean_pixel;
  logic [CH_SUM_W:0]  quad [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      quad[c] = {1'b0, head_entry.sum_a[c*CH_SUM_W +: CH_SUM_W]}
              + {1'b0, head_entry.sum_b[c*CH_SUM_W +: CH_SUM_W]};
      if (head_entry.kind == KIND_MEAN4) begin
        mean_pixel[c*8 +: 8] = quad[c][CH_SUM_W:2];
      end else begin
        mean_pixel[c*8 +: 8] = head_entry.sum_b[c*CH_SUM_W + 1 +: 8];
      end
    end
  end

  assign pop = head_valid && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_pixel  <= mean_pixel;
      last_of_level <= head_entry.last;
    end
  end

endmodule

[design/mipmap_box_downsample.sv]
// Takes ARGB8888 pixels of one mip level in raster order, one per clock, and gives the
// pixels of the next smaller level with each channel the truncated mean of its 2x2 block
// (a pair for one-wide or one-high levels). A new source item is taken every cycle as long
// as the result side drains; a result passes the line-store read stage, the queue and the
// output register after the item that completes it. The line store has one write and one
// read port and holds (MAX_WIDTH+1)/2 pair-sum words; it needs no clearing pass.
// Any configuration write restarts the level. Depends on mbd_pkg and the mbd_* modules.
module mipmap_box_downsample #(
  parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            write_enable,
  input  logic [mbd_pkg::REG_INDEX_W-1:0] write_index,
  input  logic [mbd_pkg::CFG_W-1:0]       write_data,
  input  logic                            source_valid,
  output logic                            source_stall,
  input  logic [mbd_pkg::PIXEL_W-1:0]     source_pixel,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [mbd_pkg::PIXEL_W-1:0]     result_pixel,
  output logic                            last_of_level
);
  import mbd_pkg::*;

  logic               push;
  entry_t             push_entry;
  logic               pop;
  logic               head_valid;
  entry_t             head_entry;
  logic [COUNT_W-1:0] queue_count;

  mbd_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .write_enable(write_enable),
    .write_index (write_index),
    .write_data  (write_data),
    .source_valid(source_valid),
    .source_stall(source_stall),
    .source_pixel(source_pixel),
    .queue_count (queue_count),
    .push        (push),
    .push_entry  (push_entry)
  );

  mbd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head_valid(head_valid),
    .head_entry(head_entry),
    .count     (queue_count)
  );

  mbd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_entry   (head_entry),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_pixel (result_pixel),
    .last_of_level(last_of_level)
  );

endmodule

[sim/tb_mipmap_box_downsample.sv]
// Testbench for mipmap_box_downsample: drives pixel levels of many sizes and compares every
// averaged pixel and end-of-level flag against a built-in 2x2 box-filter predictor.
// Depends on mbd_pkg and the design sources only.
`timescale 1ns / 100ps

module tb_mipmap_box_downsample;
  import mbd_pkg::*;

  localparam int MAX_W         = MAX_WIDTH_DEFAULT;
  localparam int LINE_SLOTS    = MAX_W / 2 + 1;
  localparam int SETTLE_CYCLES = 8;     // output pipeline: read stage, queue, output register
  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_ITEMS  = 850;
  localparam int CLAMP_ITEMS   = 64;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               at_end;
  } dest_item_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   write_enable = 1'b0;
  logic [REG_INDEX_W-1:0] write_index = REG_SOURCE_WIDTH;
  logic [CFG_W-1:0]       write_data = '0;
  logic                   source_valid = 1'b0;
  logic                   source_stall;
  logic [PIXEL_W-1:0]     source_pixel = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [PIXEL_W-1:0]     result_pixel;
  logic                   last_of_level;

  mipmap_box_downsample u_top (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .source_valid (source_valid),
    .source_stall (source_stall),
    .source_pixel (source_pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_pixel (result_pixel),
    .last_of_level(last_of_level)
  );

  always #2 clk = ~clk;

  // Predictor state
  dest_item_t         dest_expected[$];
  logic [SUM_W-1:0]   row_pair_sums[LINE_SLOTS];
  logic [PIXEL_W-1:0] held_px = '0;
  int                 col_pos = 0;
  int                 row_pos = 0;
  logic [CFG_W-1:0]   width_reg = 1;
  logic [CFG_W-1:0]   height_reg = 1;

  int error_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit sender_gaps = 1'b1;
  int stall_mode = 0;
  int stall_phase_left = 0;

  function automatic int clamp_dim(logic [CFG_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic logic [SUM_W-1:0] channel_pair_sums(logic [PIXEL_W-1:0] a, b);
    logic [SUM_W-1:0] s;
    s = '0;
    for (int c = 0; c < 4; c++) s[CH_SUM_W*c +: CH_SUM_W] = a[8*c +: 8] + b[8*c +: 8];
    return s;
  endfunction

  function automatic logic [PIXEL_W-1:0] avg_pair(logic [PIXEL_W-1:0] a, b);
    logic [SUM_W-1:0]   s;
    logic [PIXEL_W-1:0] r;
    s = channel_pair_sums(a, b);
    for (int c = 0; c < 4; c++) r[8*c +: 8] = s[CH_SUM_W*c +: CH_SUM_W] >> 1;
    return r;
  endfunction

  function automatic logic [PIXEL_W-1:0] avg_quad(logic [SUM_W-1:0] s1, s2);
    logic [9:0]         v;
    logic [PIXEL_W-1:0] r;
    for (int c = 0; c < 4; c++) begin
      v = s1[CH_SUM_W*c +: CH_SUM_W] + s2[CH_SUM_W*c +: CH_SUM_W];
      r[8*c +: 8] = v[9:2];
    end
    return r;
  endfunction

  function automatic void predict_downsample(logic [PIXEL_W-1:0] px);
    int               w, h, wend, hend, slot;
    logic [SUM_W-1:0] s;
    dest_item_t       d;
    bit               produce;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    wend = (w / 2) * 2;
    hend = (h / 2) * 2;
    produce = 1'b0;
    d = '0;
    if (w == 1 && h == 1) begin
      // single pixel level: consumed, nothing out
    end else if (w == 1) begin
      if (row_pos % 2 == 0) begin
        held_px = px;
      end else begin
        d.pixel = avg_pair(held_px, px);
        d.at_end = (row_pos + 1 == hend);
        produce = 1'b1;
      end
    end else if (h == 1) begin
      if (col_pos % 2 == 0) begin
        held_px = px;
      end else begin
        d.pixel = avg_pair(held_px, px);
        d.at_end = (col_pos + 1 == wend);
        produce = 1'b1;
      end
    end else begin
      if (col_pos % 2 == 0) begin
        held_px = px;
      end else begin
        slot = col_pos / 2;
        s = channel_pair_sums(held_px, px);
        if (row_pos % 2 == 0) begin
          row_pair_sums[slot] = s;
        end else begin
          d.pixel = avg_quad(row_pair_sums[slot], s);
          d.at_end = (col_pos + 1 == wend) && (row_pos + 1 == hend);
          produce = 1'b1;
        end
      end
    end
    if (produce) dest_expected.push_back(d);
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  function automatic logic [PIXEL_W-1:0] rand_pixel();
    logic [PIXEL_W-1:0] p;
    case ($urandom_range(0, 9))
      0: p = '1;
      1: p = '0;
      2: begin
        for (int c = 0; c < 4; c++) begin
          case ($urandom_range(0, 2))
            0: p[8*c +: 8] = 8'h00;
            1: p[8*c +: 8] = 8'hff;
            default: p[8*c +: 8] = $urandom_range(0, 255);
          endcase
        end
      end
      default: p = $urandom;
    endcase
    return p;
  endfunction

  task automatic idle_source();
    @(negedge clk);
    source_valid <= 1'b0;
  endtask

  task automatic send_pixel(input logic [PIXEL_W-1:0] px);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (sender_gaps) begin
        gap = $urandom_range(1, 6);
        @(negedge clk);
        source_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    source_valid <= 1'b1;
    source_pixel <= px;
    @(posedge clk);
    while (source_stall) @(posedge clk);
    predict_downsample(px);
  endtask

  task automatic wait_results_drained();
    idle_source();
    while (dest_expected.size() != 0) @(posedge clk);
  endtask

  // Trailing pixels give no result, so let the pipeline empty before touching registers.
  task automatic settle_level();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= val;
    @(posedge clk);
    case (idx)
      REG_SOURCE_WIDTH:  width_reg = val;
      REG_SOURCE_HEIGHT: height_reg = val;
    endcase
    col_pos = 0;
    row_pos = 0;
    @(negedge clk);
    write_enable <= 1'b0;
  endtask

  task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    write_reg(REG_SOURCE_WIDTH, w);
    write_reg(REG_SOURCE_HEIGHT, h);
  endtask

  // Tests

  task automatic test_power_on_level();
    // reset size is 1x1: pixels are swallowed
    send_pixel(32'hffffffff);
    send_pixel(32'h00000000);
    settle_level();
  endtask

  task automatic test_box_2x2();
    logic [PIXEL_W-1:0] px[12];
    px = '{32'hffffffff, 32'hffffffff, 32'h00000000, 32'h00000000,
           32'hfefefefe, 32'h01010101,
           32'hffffffff, 32'hffffffff, 32'h00000000, 32'h00000000,
           32'hfcfcfcfc, 32'h03030303};
    set_size(6, 2);
    foreach (px[i]) send_pixel(px[i]);
    settle_level();
  endtask

  task automatic test_thin_levels();
    // one wide with a trailing row
    set_size(1, 3);
    send_pixel(32'hfefefefe);
    send_pixel(32'h01010101);
    send_pixel(32'hffffffff);
    settle_level();
    // one high with a trailing column
    set_size(3, 1);
    send_pixel(32'h03030303);
    send_pixel(32'hfcfcfcfc);
    send_pixel(32'h00000000);
    settle_level();
    // zero acts as one
    set_size(0, 0);
    send_pixel(32'h12345678);
    send_pixel(32'h9abcdef0);
    settle_level();
  endtask

  task automatic test_max_sizes();
    // width above the line store clamps; start of a one-high level
    set_size(12'hfff, 1);
    for (int i = 0; i < CLAMP_ITEMS; i++) send_pixel(rand_pixel());
    settle_level();
    // height above the limit clamps; start of a one-wide level
    set_size(1, 12'hfff);
    for (int i = 0; i < CLAMP_ITEMS; i++) send_pixel(rand_pixel());
    settle_level();
  endtask

  task automatic test_random_levels();
    int          total, reps, lvl, count;
    logic [11:0] w, h;
    total = 0;
    while (total < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: w = $urandom_range(0, 2);
        1: w = $urandom_range(17, 64);
        default: w = $urandom_range(1, 16);
      endcase
      if (w > 16) h = $urandom_range(0, 4);
      else if ($urandom_range(0, 5) == 0) h = $urandom_range(9, 16);
      else h = $urandom_range(0, 8);
      case ($urandom_range(0, 9))
        0: write_reg(REG_SOURCE_WIDTH, w);
        1: write_reg(REG_SOURCE_HEIGHT, h);
        2, 3, 4: begin
          write_reg(REG_SOURCE_HEIGHT, h);
          write_reg(REG_SOURCE_WIDTH, w);
        end
        default: set_size(w, h);
      endcase
      sender_gaps = ($urandom_range(0, 3) != 0);
      lvl = clamp_dim(width_reg, MAX_W) * clamp_dim(height_reg, MAX_HEIGHT);
      reps = (lvl > 256) ? 1 : $urandom_range(1, 3);
      count = reps * lvl;
      // some levels are cut short before the next register write
      if ($urandom_range(0, 5) == 0) count = $urandom_range(1, lvl);
      for (int i = 0; i < count; i++) begin
        send_pixel(rand_pixel());
        if ($urandom_range(0, 49) == 0) wait_results_drained();
      end
      total += count;
      settle_level();
    end
    sender_gaps = 1'b1;
  endtask

  // Receiver stall pattern, the mode changing whenever its phase runs out
  always @(negedge clk) begin
    if (stall_phase_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_phase_left = $urandom_range(20, 200);
    end
    stall_phase_left--;
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 3) == 0);
      2: result_stall <= ($urandom_range(0, 3) != 0);
      default: result_stall <= (stall_phase_left % 16) < 5;
    endcase
  end

  task automatic note_mismatch(input string what, input logic [PIXEL_W-1:0] exp_v,
                               input logic [PIXEL_W-1:0] act_v);
    error_count++;
    if (error_count <= 10)
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    dest_item_t d;
    if (!rst && result_valid === 1'b1 && result_stall == 1'b0) begin
      if (dest_expected.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: result %h with nothing expected", $time, result_pixel);
      end else begin
        d = dest_expected.pop_front();
        if (result_pixel !== d.pixel) note_mismatch("result_pixel", d.pixel, result_pixel);
        if (last_of_level !== d.at_end)
          note_mismatch("last_of_level", d.at_end, last_of_level);
      end
    end
  end

  always @(posedge clk) begin
    if ((source_valid && source_stall === 1'b0) || (result_valid === 1'b1 && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_power_on_level();
    test_box_2x2();
    test_thin_levels();
    test_max_sizes();
    test_random_levels();
    settle_level();
    if (error_count == 0 && dest_expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
